/* src/bat_pkg.sv */
// Shared types and constants for the broadcast ack tracking table.
// No dependencies.
`timescale 1ns / 1ps

package bat_pkg;

  localparam int ID_W         = 5;
  localparam int SEQ_W        = 32;
  localparam int TOTAL_W      = 5;
  localparam int STATUS_W     = 2;

  localparam int DEF_TABLE_DEPTH   = 32;
  localparam int DEF_MAX_PROCESSES = 16;

  localparam logic [ID_W-1:0] PROC_COUNT_RESET = ID_W'(16);

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  origin_id;
    logic [SEQ_W-1:0] sequence_number;
    logic [ID_W-1:0]  acker_id;
  } bat_in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  acker_total;
    logic                created_entry;
    logic                repeat_ack;
    logic [STATUS_W-1:0] status;
  } bat_out_t;

  // request as handed to the sequencer, with the id check already done
  typedef struct packed {
    logic [ID_W-1:0]  origin_id;
    logic [SEQ_W-1:0] sequence_number;
    logic [ID_W-1:0]  acker_id;
    logic             bad_id;
  } bat_req_t;

endpackage

/* src/broadcast_ack_tracking_table.sv */
// Top level of the broadcast ack tracking table. Holds the process count
// register and the id check. Uses bat_pkg and bat_seq.
`timescale 1ns / 1ps

// One request is taken at a time: after it is accepted, the stored entries
// are read one by one through the single memory read port and each is
// compared with the request key; the scan ends at the first match or after
// the last stored entry, and a request with a bad id reads no entry. The
// result sits in an output register, so the next request is accepted while
// it waits. The table needs no clearing after reset. cfg_ready is always
// high; process_count should be written only while no request is in flight.
module broadcast_ack_tracking_table
  import bat_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bat_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bat_out_t        out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ID_W-1:0] cfg_data
);

  logic [ID_W-1:0] pcount_r, pcount_nxt;
  logic [ID_W:0]   id_limit;
  logic            origin_ok, acker_ok;
  bat_req_t        req;

  assign cfg_ready  = 1'b1;
  assign pcount_nxt = (cfg_valid && cfg_ready) ? cfg_data : pcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= PROC_COUNT_RESET;
    end else begin
      pcount_r <= pcount_nxt;
    end
  end

  // membership limit is capped at the acker map width
  assign id_limit = (MAX_PROCESSES < int'(pcount_r)) ? (ID_W+1)'(MAX_PROCESSES)
                                                      : {1'b0, pcount_r};

  assign origin_ok = (in_data.origin_id != '0) && ({1'b0, in_data.origin_id} <= id_limit);
  assign acker_ok  = (in_data.acker_id != '0) && ({1'b0, in_data.acker_id} <= id_limit);

  assign req.origin_id       = in_data.origin_id;
  assign req.sequence_number = in_data.sequence_number;
  assign req.acker_id        = in_data.acker_id;
  assign req.bad_id          = !(origin_ok && acker_ok);

  bat_seq #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/bat_mem.sv */
// Entry storage for the ack table: one write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module bat_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 58
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/bat_seq.sv */
// Search sequencer: scans the entry memory with one shared compare unit,
// updates or appends the entry and holds the result. Uses bat_pkg, bat_mem.
`timescale 1ns / 1ps

module bat_seq
  import bat_pkg::*;
#(
  parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_ready,
  input  bat_req_t req,
  output logic     out_valid,
  input  logic     out_ready,
  output bat_out_t out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = MAX_PROCESSES;
  localparam int EW = ID_W + SEQ_W + MW + TOTAL_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic            state_r, state_nxt;
  bat_req_t        req_r, req_nxt;
  logic [CW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   cidx_r, cidx_nxt;
  logic            pend_r, pend_nxt;
  logic [CW-1:0]   used_r, used_nxt;
  logic            out_valid_r, out_valid_nxt;
  bat_out_t        out_r, out_nxt;

  logic [EW-1:0]      rd_data;
  logic [EW-1:0]      wr_data;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic               rd_en;
  logic [ID_W-1:0]    st_origin;
  logic [SEQ_W-1:0]   st_seq;
  logic [MW-1:0]      st_map;
  logic [TOTAL_W-1:0] st_total;
  logic [TOTAL_W-1:0] inc_total;
  logic [MW-1:0]      mask;
  logic               match, issue_ok, hit, miss, done, can_fin, fin, full, seen;
  bat_out_t           res;

  assign st_origin = rd_data[EW-1 -: ID_W];
  assign st_seq    = rd_data[EW-ID_W-1 -: SEQ_W];
  assign st_map    = rd_data[TOTAL_W +: MW];
  assign st_total  = rd_data[TOTAL_W-1:0];
  assign inc_total = st_total + TOTAL_W'(1);

  assign mask = MW'(1) << (req_r.acker_id - ID_W'(1));

  // shared compare unit: one stored entry per cycle against the request key
  assign match = pend_r && (st_origin == req_r.origin_id) &&
                 (st_seq == req_r.sequence_number);

  assign issue_ok = (addr_r != used_r);
  assign hit      = !req_r.bad_id && match;
  assign miss     = !req_r.bad_id && !issue_ok && !match;
  assign done     = (state_r == ST_SCAN) && (req_r.bad_id || hit || miss);
  assign can_fin  = !out_valid_r || out_ready;
  assign fin      = done && can_fin;
  assign full     = (used_r == CW'(TABLE_DEPTH));
  assign seen     = |(st_map & mask);
  assign rd_en    = (state_r == ST_SCAN) && !req_r.bad_id && issue_ok && !match;

  assign wr_en   = fin && ((hit && !seen) || (miss && !full));
  assign wr_addr = hit ? cidx_r : used_r[AW-1:0];
  assign wr_data = hit ? {st_origin, st_seq, st_map | mask, inc_total}
                       : {req_r.origin_id, req_r.sequence_number, mask, TOTAL_W'(1)};

  always_comb begin
    res = '0;
    if (req_r.bad_id) begin
      res.status = STATUS_BAD_ID;
    end else if (hit) begin
      res.status = STATUS_OK;
      if (seen) begin
        res.acker_total = st_total;
        res.repeat_ack  = 1'b1;
      end else begin
        res.acker_total = inc_total;
      end
    end else if (full) begin
      res.status = STATUS_FULL;
    end else begin
      res.status        = STATUS_OK;
      res.acker_total   = TOTAL_W'(1);
      res.created_entry = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    cidx_nxt      = cidx_r;
    pend_nxt      = pend_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_nxt   = req;
          addr_nxt  = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          addr_nxt = addr_r + CW'(1);
          cidx_nxt = addr_r[AW-1:0];
        end
        // hold the compare slot while a finished result waits for room
        pend_nxt = done ? pend_r : rd_en;
        if (fin) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res;
          state_nxt     = ST_IDLE;
          if (miss && !full) begin
            used_nxt = used_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    addr_r <= addr_nxt;
    cidx_r <= cidx_nxt;
    out_r  <= out_nxt;
  end

  bat_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign req_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (addr_r < used_r))
    else $error("read beyond used entries");

  a_wr_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_SCAN) && fin && !req_r.bad_id)
    else $error("table write outside a finishing scan");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && miss && !full) |=> (used_r == $past(used_r) + CW'(1)))
    else $error("append did not bump entry count");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && req_valid) |=> (state_r == ST_SCAN && !out_valid_nxt) ||
      (state_r == ST_SCAN))
    else $error("accepted request did not start a scan");
`endif

endmodule
